### rtl/qas_pkg.sv
// Shared types and constants for the quoted argument splitter.
package qas_pkg;

  localparam int CP_W     = 21;
  localparam int ARG_W    = 9;
  localparam int SEP_NUM  = 7;
  localparam int CNT_W    = 3;
  localparam int IDX_W    = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW  = 2;
  localparam int FIFO_CW  = 3;

  localparam logic [ARG_W-1:0] MAX_ARGS = 9'd256;

  localparam logic [CP_W-1:0] DQUOTE = 21'd34;
  localparam logic [CP_W-1:0] SQUOTE = 21'd39;

  localparam logic [CNT_W-1:0] SEP_COUNT_RESET = 3'd4;
  localparam logic [CP_W-1:0] SEP_RESET [SEP_NUM] =
    '{21'd32, 21'd9, 21'd10, 21'd13, 21'd0, 21'd0, 21'd0};

  // register index of the separator count; separators follow from 1 up
  localparam logic [IDX_W-1:0] CFG_SEP_COUNT = 3'd0;

  typedef enum logic [2:0] {
    KIND_CHAR      = 3'd0,
    KIND_ARG_END   = 3'd1,
    KIND_LINE_DONE = 3'd2,
    KIND_ENC_ERR   = 3'd3,
    KIND_TOO_MANY  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_DOUBLE = 2'd1,
    Q_SINGLE = 2'd2
  } quote_t;

  typedef struct packed {
    kind_t             kind;
    logic [CP_W-1:0]   char_value;
    logic [ARG_W-1:0]  arg_num;
    logic              last;
  } res_t;

  // results produced by one accepted transaction
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

### rtl/qas_sep_match.sv
// Separator registers and parallel code point compare.
module qas_sep_match
  import qas_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CP_W-1:0]  cfg_wdata,
  input  logic [CP_W-1:0]  cp,
  output logic             is_sep
);

  logic [CNT_W-1:0] count_r;
  logic [CP_W-1:0]  sep_r [SEP_NUM];
  logic [SEP_NUM-1:0] hit;
  logic [IDX_W-1:0] sep_idx;

  assign sep_idx = cfg_index - 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= SEP_COUNT_RESET;
      for (int i = 0; i < SEP_NUM; i++) begin
        sep_r[i] <= SEP_RESET[i];
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_SEP_COUNT) begin
        count_r <= cfg_wdata[CNT_W-1:0];
      end else begin
        sep_r[sep_idx] <= cfg_wdata;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SEP_NUM; i++) begin
      hit[i] = (CNT_W'(i) < count_r) && (sep_r[i] == cp);
    end
  end

  assign is_sep = |hit;

endmodule

### rtl/qas_core.sv
// Line state and result generation for one transaction.
module qas_core
  import qas_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_acc,
  input  logic [CP_W-1:0] cp,
  input  logic            line_end,
  input  logic            bad,
  input  logic            is_sep,
  output push_t           push
);

  logic             inside_r, inside_nxt;
  quote_t           quote_r, quote_nxt;
  logic [ARG_W-1:0] total_r, total_nxt;
  logic             drop_r, drop_nxt;
  quote_t           q_eff;
  logic [ARG_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      quote_r  <= Q_NONE;
      total_r  <= '0;
      drop_r   <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
      quote_r  <= quote_nxt;
      total_r  <= total_nxt;
      drop_r   <= drop_nxt;
    end
  end

  always_comb begin
    inside_nxt = inside_r;
    quote_nxt  = quote_r;
    total_nxt  = total_r;
    drop_nxt   = drop_r;
    push       = '0;
    q_eff      = inside_r ? quote_r : Q_NONE;
    idx        = '0;
    if (in_acc) begin
      if (drop_r) begin
        if (line_end) begin
          drop_nxt = 1'b0;
        end
      end else if (bad) begin
        push.cnt = 2'd1;
        push.r0  = '{kind: KIND_ENC_ERR, char_value: '0, arg_num: total_r, last: 1'b1};
        inside_nxt = 1'b0;
        quote_nxt  = Q_NONE;
        total_nxt  = '0;
        drop_nxt   = !line_end;
      end else if (line_end) begin
        if (inside_r) begin
          push.cnt = 2'd2;
          push.r0  = '{kind: KIND_ARG_END, char_value: '0, arg_num: total_r - 9'd1,
                       last: 1'b0};
          push.r1  = '{kind: KIND_LINE_DONE, char_value: '0, arg_num: total_r, last: 1'b1};
        end else begin
          push.cnt = 2'd1;
          push.r0  = '{kind: KIND_LINE_DONE, char_value: '0, arg_num: total_r, last: 1'b1};
        end
        inside_nxt = 1'b0;
        quote_nxt  = Q_NONE;
        total_nxt  = '0;
      end else if (!inside_r && is_sep) begin
        // separator run between arguments: skipped
      end else if (!inside_r && (total_r >= MAX_ARGS)) begin
        push.cnt = 2'd1;
        push.r0  = '{kind: KIND_TOO_MANY, char_value: '0, arg_num: total_r, last: 1'b1};
        inside_nxt = 1'b0;
        quote_nxt  = Q_NONE;
        total_nxt  = '0;
        drop_nxt   = 1'b1;
      end else begin
        if (!inside_r) begin
          total_nxt = total_r + 9'd1;
        end
        inside_nxt = 1'b1;
        quote_nxt  = q_eff;
        idx        = total_nxt - 9'd1;
        case (q_eff)
          Q_NONE: begin
            if (cp == DQUOTE) begin
              quote_nxt = Q_DOUBLE;
            end else if (cp == SQUOTE) begin
              quote_nxt = Q_SINGLE;
            end else if (is_sep) begin
              push.cnt   = 2'd1;
              push.r0    = '{kind: KIND_ARG_END, char_value: '0, arg_num: idx, last: 1'b1};
              inside_nxt = 1'b0;
            end else begin
              push.cnt = 2'd1;
              push.r0  = '{kind: KIND_CHAR, char_value: cp, arg_num: idx, last: 1'b1};
            end
          end
          Q_DOUBLE: begin
            if (cp == DQUOTE) begin
              quote_nxt = Q_NONE;
            end else begin
              push.cnt = 2'd1;
              push.r0  = '{kind: KIND_CHAR, char_value: cp, arg_num: idx, last: 1'b1};
            end
          end
          Q_SINGLE: begin
            if (cp == SQUOTE) begin
              quote_nxt = Q_NONE;
            end else begin
              push.cnt = 2'd1;
              push.r0  = '{kind: KIND_CHAR, char_value: cp, arg_num: idx, last: 1'b1};
            end
          end
          default: begin
            quote_nxt = Q_NONE;
          end
        endcase
      end
    end
  end

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && drop_r) |-> (push.cnt == 2'd0))
    else $error("results produced while dropping a line");

  a_quote_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (quote_r != Q_NONE) |-> inside_r)
    else $error("quote open outside an argument");

  a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r <= MAX_ARGS) && (!drop_r || !inside_r))
    else $error("argument count or drop state out of range");

endmodule

### rtl/qas_out_fifo.sv
// Result queue: takes up to two results per cycle, issues one per cycle while out_ready is high.
module qas_out_fifo
  import qas_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign room      = cnt_r <= FIFO_CW'(FIFO_DEPTH - 2);
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push.cnt;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + {1'b0, push.cnt} - {2'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("result queue written without room");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule

### rtl/quoted_argument_splitter.sv
// Quoted argument splitter: splits a stream of code points into arguments.
//
// Input channel (in_*): one code point per transaction; in_tlast ends the
// command line, in_tuser flags a decoding error at that position.
// Output channel (out_*): char, argument-end, line-done and error results;
// out_tlast marks the last result caused by one input transaction.
// Configuration (cfg_*): separator count and separator code points; the user must
// write them only while no transaction is in flight, as the block has no check for this.
// Each result is registered in the result queue before it reaches the output.
// Throughput: one input per cycle while in_tready is high; a line end closing an
// open argument yields two results, drained one per cycle while out_tready is high
// from a four-entry result queue. in_tready is high while the queue has room for
// two results, so a stalled receiver backs up into the input and nothing is lost.
// Reset clears line state and the queue and loads the default separators
// (space, tab, line feed, carriage return).
module quoted_argument_splitter
  import qas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] code_point, [23:21] zero
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] bad_encoding
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [20:0] char_value, [29:21] argument_number, [31:30] zero
  output logic        out_tlast,
  output logic [2:0]  out_tuser,  // [2:0] kind
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_wdata
);

  logic  in_acc;
  logic  is_sep;
  push_t push;
  res_t  out_res;

  assign in_acc = in_tvalid && in_tready;

  qas_sep_match u_sep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cp        (in_tdata[CP_W-1:0]),
    .is_sep    (is_sep)
  );

  qas_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .cp       (in_tdata[CP_W-1:0]),
    .line_end (in_tlast),
    .bad      (in_tuser),
    .is_sep   (is_sep),
    .push     (push)
  );

  qas_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {2'b00, out_res.arg_num, out_res.char_value};
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.kind;

endmodule

### dv/tb_quoted_argument_splitter.sv
`timescale 1ns / 100ps
// Self-checking testbench for quoted_argument_splitter: command lines against a line-state predictor.
module tb_quoted_argument_splitter;
  import qas_pkg::*;

  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
  localparam logic [CP_W-1:0] SP = 21'd32;
  localparam logic [CP_W-1:0] TAB = 21'd9;
  localparam logic [CP_W-1:0] CH_A = 21'd97;
  localparam int ARG_LIMIT = int'(MAX_ARGS);
  localparam int QUIET_LIMIT = 200;
  localparam int SETTLE_CYCLES = 3;
  localparam int RANDOM_ITEMS = 560;
  localparam int RANDOM_PHASES = 8;

  typedef logic [CP_W-1:0] sep_set_t [SEP_NUM];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [20:0] code_point, [23:21] zero
  logic        in_tlast = 1'b0;
  logic        in_tuser = 1'b0; // [0] bad_encoding
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [31:0] out_tdata;       // [20:0] char_value, [29:21] argument_number, [31:30] zero
  logic        out_tlast;
  logic [2:0]  out_tuser;       // [2:0] kind
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [20:0] cfg_wdata = '0;

  quoted_argument_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow configuration and line state
  logic [CNT_W-1:0] sep_count = SEP_COUNT_RESET;
  sep_set_t         sep_table = SEP_RESET;
  bit               in_arg = 1'b0;
  quote_t           open_q = Q_NONE;
  int               arg_total = 0;
  bit               dropping = 1'b0;

  res_t tokens_due[$];
  int   fail_count = 0;
  int   items_sent = 0;
  int   tx_gap_max = 0;
  int   rx_gap_max = 0;
  int   quiet_cycles = 0;

  function automatic bit sep_hit(logic [CP_W-1:0] cp);
    for (int s = 0; s < int'(sep_count); s++)
      if (sep_table[s] == cp) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_line_state();
    in_arg = 1'b0;
    open_q = Q_NONE;
    arg_total = 0;
    dropping = 1'b0;
  endfunction

  function automatic res_t make_token(kind_t k, logic [CP_W-1:0] v, int num);
    res_t t;
    t.kind = k;
    t.char_value = v;
    t.arg_num = num[ARG_W-1:0];
    t.last = 1'b0;
    return t;
  endfunction

  // expected results of one input transaction, appended to tokens_due
  function automatic void split_code_point(logic [CP_W-1:0] cp, bit eol, bit bad);
    res_t step[$];
    bit   skip;
    int   idx;
    skip = 1'b0;
    if (dropping) begin
      if (eol) clear_line_state();
    end else if (bad) begin
      step.push_back(make_token(KIND_ENC_ERR, '0, arg_total));
      clear_line_state();
      dropping = !eol;
    end else if (eol) begin
      if (in_arg) step.push_back(make_token(KIND_ARG_END, '0, arg_total - 1));
      step.push_back(make_token(KIND_LINE_DONE, '0, arg_total));
      clear_line_state();
    end else begin
      if (!in_arg) begin
        // outside an argument a separator wins over a quote
        if (sep_hit(cp)) begin
          skip = 1'b1;
        end else if (arg_total >= ARG_LIMIT) begin
          step.push_back(make_token(KIND_TOO_MANY, '0, arg_total));
          clear_line_state();
          dropping = 1'b1;
          skip = 1'b1;
        end else begin
          arg_total++;
          in_arg = 1'b1;
          open_q = Q_NONE;
        end
      end
      if (!skip) begin
        idx = arg_total - 1;
        if (open_q == Q_NONE) begin
          if (cp == DQUOTE) open_q = Q_DOUBLE;
          else if (cp == SQUOTE) open_q = Q_SINGLE;
          else if (sep_hit(cp)) begin
            step.push_back(make_token(KIND_ARG_END, '0, idx));
            in_arg = 1'b0;
          end else step.push_back(make_token(KIND_CHAR, cp, idx));
        end else if (cp == ((open_q == Q_DOUBLE) ? DQUOTE : SQUOTE)) begin
          open_q = Q_NONE;
        end else begin
          step.push_back(make_token(KIND_CHAR, cp, idx));
        end
      end
    end
    if (step.size() > 0) step[step.size()-1].last = 1'b1;
    foreach (step[i]) tokens_due.push_back(step[i]);
  endfunction

  function automatic logic [CP_W-1:0] rand_cp();
    return CP_W'($urandom_range(CP_MAX, 0));
  endfunction

  // code point that opens an argument and is copied as a plain char
  function automatic logic [CP_W-1:0] plain_cp();
    logic [CP_W-1:0] c;
    c = $urandom_range(1, 0) ? CP_W'($urandom_range(126, 33)) : rand_cp();
    while (sep_hit(c) || c == DQUOTE || c == SQUOTE)
      c = $urandom_range(1, 0) ? CP_W'($urandom_range(126, 33)) : rand_cp();
    return c;
  endfunction

  function automatic logic [CP_W-1:0] active_sep();
    return sep_table[$urandom_range(int'(sep_count) - 1, 0)];
  endfunction

  // biased toward separators (active or not), quotes and extremes
  function automatic logic [CP_W-1:0] pick_cp();
    case ($urandom_range(9, 0))
      0, 1, 2: return sep_table[$urandom_range(SEP_NUM - 1, 0)];
      3:       return DQUOTE;
      4:       return SQUOTE;
      5:       return $urandom_range(1, 0) ? '0 : CP_MAX;
      6, 7:    return CP_W'($urandom_range(126, 33));
      default: return rand_cp();
    endcase
  endfunction

  function automatic logic [CP_W-1:0] rand_sep();
    case ($urandom_range(5, 0))
      0:       return CP_W'($urandom_range(101, 97));
      1:       return $urandom_range(1, 0) ? DQUOTE : SQUOTE;
      2:       return $urandom_range(1, 0) ? '0 : CP_MAX;
      3:       return SP;
      default: return rand_cp();
    endcase
  endfunction

  task automatic push_code_point(input logic [CP_W-1:0] cp, input bit eol, input bit bad);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {3'b000, cp};
    in_tlast <= eol;
    in_tuser <= bad;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    split_code_point(cp, eol, bad);
    items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_separators(input logic [CNT_W-1:0] count, input sep_set_t seps);
    for (int r = 0; r <= SEP_NUM; r++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_SEP_COUNT + r[IDX_W-1:0];
      if (r == 0) cfg_wdata <= CP_W'(count);
      else cfg_wdata <= seps[r-1];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    sep_count = count;
    sep_table = seps;
  endtask

  task automatic random_line();
    int  len;
    int  bad_at;
    bit  bad_eol;
    len = $urandom_range(12, 0);
    bad_at = ($urandom_range(6, 0) == 0) ? $urandom_range(len, 0) : -1;
    for (int i = 0; i <= len; i++) begin
      if (i == bad_at) begin
        bad_eol = 1'($urandom_range(1, 0));
        push_code_point(rand_cp(), bad_eol, 1'b1);
        if (bad_eol) return;
      end else if (i == len) begin
        push_code_point(rand_cp(), 1'b1, 1'b0);
      end else begin
        push_code_point(pick_cp(), 1'b0, 1'b0);
      end
    end
  endtask

  // reset separators; zero and the top code point are ordinary chars here
  task automatic test_default_separators();
    tx_gap_max = 8;
    rx_gap_max = 8;
    push_code_point(SP, 1'b0, 1'b0);
    push_code_point(CH_A, 1'b0, 1'b0);
    push_code_point(TAB, 1'b0, 1'b0);
    push_code_point(CP_MAX, 1'b0, 1'b0);
    push_code_point('0, 1'b0, 1'b0);
    push_code_point(rand_cp(), 1'b1, 1'b0);
    settle();
  endtask

  // joined quoted parts, the other quote as literal, empty pair, unclosed quote
  task automatic test_quoting();
    push_code_point(DQUOTE, 1'b0, 1'b0);
    push_code_point(SP, 1'b0, 1'b0);
    push_code_point(DQUOTE, 1'b0, 1'b0);
    push_code_point(SQUOTE, 1'b0, 1'b0);
    push_code_point(DQUOTE, 1'b0, 1'b0);
    push_code_point(SQUOTE, 1'b0, 1'b0);
    push_code_point(SP, 1'b0, 1'b0);
    push_code_point(DQUOTE, 1'b0, 1'b0);
    push_code_point(DQUOTE, 1'b0, 1'b0);
    push_code_point(SP, 1'b0, 1'b0);
    push_code_point(SQUOTE, 1'b0, 1'b0);
    push_code_point(rand_cp(), 1'b1, 1'b0);
    settle();
  endtask

  // empty line, decode error then dropped input, error together with line end
  task automatic test_line_errors();
    push_code_point(rand_cp(), 1'b1, 1'b0);
    push_code_point(CH_A, 1'b0, 1'b0);
    push_code_point(rand_cp(), 1'b0, 1'b1);
    push_code_point(CH_A, 1'b0, 1'b0);
    push_code_point(rand_cp(), 1'b1, 1'b0);
    push_code_point(rand_cp(), 1'b1, 1'b1);
    settle();
  endtask

  // double quote as separator: skipped outside, opens a quote inside
  task automatic test_quote_against_separator();
    sep_set_t s;
    foreach (s[i]) s[i] = rand_cp();
    s[0] = DQUOTE;
    s[1] = '0;
    load_separators(3'd2, s);
    push_code_point(DQUOTE, 1'b0, 1'b0);
    push_code_point('0, 1'b0, 1'b0);
    push_code_point(CH_A, 1'b0, 1'b0);
    push_code_point(DQUOTE, 1'b0, 1'b0);
    push_code_point('0, 1'b0, 1'b0);
    push_code_point(SP, 1'b0, 1'b0);
    push_code_point(DQUOTE, 1'b0, 1'b0);
    push_code_point('0, 1'b0, 1'b0);
    push_code_point(rand_cp(), 1'b1, 1'b0);
    settle();
  endtask

  task automatic test_random_lines();
    sep_set_t s;
    int       stop_at;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      foreach (s[i]) s[i] = rand_sep();
      case (phase)
        0: load_separators(3'd7, '{SP, TAB, 21'd0, CP_MAX, SQUOTE, 21'd10, 21'd13});
        1: load_separators(3'd0, s);
        2: begin
          s[0] = CP_MAX;
          load_separators(3'd1, s);
        end
        3: load_separators(SEP_COUNT_RESET, SEP_RESET);
        default: load_separators(CNT_W'($urandom_range(7, 0)), s);
      endcase
      stop_at = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < stop_at) begin
        // one phase runs with no idling on either side
        tx_gap_max = (phase == 3 || $urandom_range(3, 0) == 0) ? 0 : 8;
        rx_gap_max = (phase == 3 || $urandom_range(3, 0) == 0) ? 0 : 8;
        random_line();
      end
      settle();
    end
  endtask

  // full line of arguments, then one past the limit and the dropped rest of the line
  task automatic test_argument_limit();
    sep_set_t s;
    foreach (s[i]) s[i] = rand_cp();
    s[0] = SP;
    s[1] = TAB;
    s[2] = CP_MAX;
    load_separators(3'd3, s);
    tx_gap_max = 1;
    rx_gap_max = 2;
    for (int k = 0; k < ARG_LIMIT; k++) begin
      push_code_point(plain_cp(), 1'b0, 1'b0);
      push_code_point(active_sep(), 1'b0, 1'b0);
    end
    push_code_point(plain_cp(), 1'b0, 1'b0);
    push_code_point(plain_cp(), 1'b0, 1'b0);
    push_code_point(rand_cp(), 1'b0, 1'b1);
    push_code_point(rand_cp(), 1'b1, 1'b0);
    push_code_point(plain_cp(), 1'b0, 1'b0);
    push_code_point(rand_cp(), 1'b1, 1'b0);
    settle();
  endtask

  function automatic void flag_field(string field, int unsigned want, int unsigned seen);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t ns: %s differs, expected %0d, actual %0d", $time, field, want, seen);
  endfunction

  always @(posedge clk) begin : token_check
    res_t want;
    if (out_tvalid && out_tready) begin
      if (tokens_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t ns: result with none expected, expected nothing, actual kind %0d data %h",
                   $time, out_tuser, out_tdata);
      end else begin
        want = tokens_due.pop_front();
        if (out_tuser != want.kind) flag_field("kind", want.kind, out_tuser);
        if (out_tdata[CP_W-1:0] != want.char_value)
          flag_field("char_value", want.char_value, out_tdata[CP_W-1:0]);
        if (out_tdata[CP_W+ARG_W-1:CP_W] != want.arg_num)
          flag_field("argument_number", want.arg_num, out_tdata[CP_W+ARG_W-1:CP_W]);
        if (out_tlast != want.last) flag_field("final_of_run", want.last, out_tlast);
      end
    end
  end

  // receiver draws a stall after each transaction it takes
  initial begin : token_sink
    int stall;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        stall = $urandom_range(rx_gap_max, 0);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_separators();
    test_quoting();
    test_line_errors();
    test_quote_against_separator();
    test_random_lines();
    test_argument_limit();
    settle();
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
